>>> src/assert_macros.svh
// Assertion macros used by the top level of the square-wave sequencer mixer.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked outside reset only.
`define PSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define PSM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PSM_ASSERT(lbl, prop, msg)
`define PSM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> src/psm_pkg.sv
// Package for the square-wave sequencer mixer: payload types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package psm_pkg;

    localparam int VOICES_DEF     = 4;
    localparam int NOTE_DEPTH_DEF = 64;

    localparam logic [6:0]  LEVEL_RST = 7'd40;
    localparam logic [7:0]  CLIP_RST  = 8'd220;
    localparam logic [23:0] TICK_US   = 24'd125;

    // Divider geometry: 39-bit dividend, 16-bit divisor, low 32 quotient bits kept.
    localparam int DIV_NW = 39;
    localparam int DIV_DW = 16;
    localparam int DIV_QW = 32;
    localparam int DIV_CW = 6;
    // 2^32 * 1e6 / 8000 = 125 * 2^32
    localparam logic [DIV_NW-1:0] DIV_STEP_NUM = 39'd536870912000;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_BIND  = 2'd2;
    localparam logic [1:0] CMD_OFF   = 2'd3;

    localparam logic REG_LEVEL      = 1'b0;
    localparam logic REG_CLIP_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  track;
        logic [5:0]  note_index;
        logic [23:0] note_delay;
        logic [15:0] note_period;
        logic [23:0] note_length;
        logic [6:0]  note_count;
        logic [7:0]  shift_div;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pwm_level;
        logic [3:0] active_voices;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIND,
        S_VOICE,
        S_NOTE_RD,
        S_NEXT_RD,
        S_DIV1,
        S_PREP2,
        S_DIV2,
        S_APPLY,
        S_MIX,
        S_OUT
    } t_state;

endpackage

>>> src/psm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on psm_pkg.
`timescale 1ns / 1ps
module psm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psm_pkg::DIV_NW-1:0]    i_num,
    input  logic [psm_pkg::DIV_DW-1:0]    i_den,
    output logic                          o_done,
    output logic [psm_pkg::DIV_QW-1:0]    o_quot
);
    logic                        r_run;
    logic                        r_done;
    logic [psm_pkg::DIV_CW-1:0]  r_cnt;
    logic [psm_pkg::DIV_NW-1:0]  r_num;
    logic [psm_pkg::DIV_DW:0]    r_rem;
    logic [psm_pkg::DIV_DW-1:0]  r_den;
    logic [psm_pkg::DIV_QW-1:0]  r_q;

    logic [psm_pkg::DIV_DW:0]    trial;
    logic                        qbit;

    assign trial = {r_rem[psm_pkg::DIV_DW-1:0], r_num[psm_pkg::DIV_NW-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= psm_pkg::DIV_CW'(psm_pkg::DIV_NW);
            end else if (r_run) begin
                r_cnt <= r_cnt - psm_pkg::DIV_CW'(1);
                if (r_cnt == psm_pkg::DIV_CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_run) begin
            r_num <= {r_num[psm_pkg::DIV_NW-2:0], 1'b0};
            r_rem <= qbit ? (trial - {1'b0, r_den}) : trial;
            r_q   <= {r_q[psm_pkg::DIV_QW-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> src/psm_note_store.sv
// Note store: one write port, one registered read port, no reset.
// No dependencies.
`timescale 1ns / 1ps
module psm_note_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/polyphonic_square_sequencer_mixer_top.sv
// Top level of the polyphonic square-wave sequencer mixer.
// Depends on psm_pkg, psm_div, psm_note_store and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//  - Command channel: a transaction is taken on a rising edge with start high
//    and busy low. Commands: sample tick, write note, bind track, all off.
//  - Write note and all off finish in the accepting cycle (busy stays low).
//    Bind reads the track's first note from the store while busy is high.
//  - A sample tick walks the voices one at a time. An idle voice passes
//    S_VOICE and S_MIX only; a voice that starts a note also passes
//    S_NOTE_RD, S_NEXT_RD, up to two runs of the bit-serial divider (pitch
//    shift, then the phase step) and S_APPLY before S_MIX. Busy stays high
//    for the whole tick; the result shows in its last busy state, S_OUT.
//  - Result: o_res_valid pulses for one cycle with o_result; the receiver
//    cannot stall, so the result is gone after that cycle.
//  - Config: APB-style, amplitude at 0x0, clip_limit at 0x4, pready tied
//    high. Write only while busy is low.
//  - Reset (sync, active low) disarms and silences all tracks, restores the
//    register defaults; the note store keeps its contents (undefined at
//    power-up), so write notes before binding a track.
module polyphonic_square_sequencer_mixer_top #(
    parameter int VOICES     = psm_pkg::VOICES_DEF,
    parameter int NOTE_DEPTH = psm_pkg::NOTE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  psm_pkg::t_in_item    i_item,
    output logic                 o_res_valid,
    output psm_pkg::t_out_item   o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int IW     = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
    localparam int NW     = $clog2(NOTE_DEPTH + 1);
    localparam int MDEPTH = VOICES * NOTE_DEPTH;
    localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    // Mix accumulator: VOICES*127 in magnitude, at least +/-255 for the clamp.
    localparam int ACC_W  = ($clog2(VOICES * 128) + 2 > 10) ? $clog2(VOICES * 128) + 2 : 10;

    // Per-voice state
    logic [31:0]   r_phase [VOICES];
    logic [31:0]   r_step  [VOICES];
    logic          r_on    [VOICES];
    logic          r_armed [VOICES];
    logic [NW-1:0] r_next  [VOICES];
    logic [NW-1:0] r_cnt   [VOICES];
    logic [23:0]   r_delay [VOICES];
    logic [23:0]   r_dur   [VOICES];
    logic [7:0]    r_shdiv [VOICES];

    psm_pkg::t_state    r_state, n_state;
    logic [VW-1:0]      r_vidx;
    logic [NW-1:0]      r_bind_n;
    logic [7:0]         r_bind_sh;
    logic [15:0]        r_per;
    logic [23:0]        r_ndur;
    logic [31:0]        r_nstep;
    logic signed [ACC_W-1:0] r_acc;
    logic [3:0]         r_mask;
    logic [6:0]         r_level;
    logic [7:0]         r_clip;

    logic                      accept;
    logic                      cmd_acc;
    logic                      trk_ok;
    logic                      idx_ok;
    logic [VW-1:0]             in_trk;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic [63:0]               mem_rdata;
    logic                      div_start;
    logic [psm_pkg::DIV_NW-1:0] div_num;
    logic [psm_pkg::DIV_DW-1:0] div_den;
    logic                      div_done;
    logic [psm_pkg::DIV_QW-1:0] div_quot;
    logic                      last_voice;
    logic [31:0]               phase_sum;
    logic                      cfg_wr;

    function automatic logic [AW-1:0] note_addr(input logic [VW-1:0] t,
                                                input logic [IW-1:0] i);
        note_addr = AW'(t) * AW'(NOTE_DEPTH) + AW'(i);
    endfunction

    function automatic logic [23:0] count_down(input logic [23:0] v);
        count_down = (v > psm_pkg::TICK_US) ? v - psm_pkg::TICK_US : 24'd0;
    endfunction

    assign busy    = (r_state != psm_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign cmd_acc = accept && (i_item.command != psm_pkg::CMD_TICK);
    assign in_trk  = VW'(i_item.track);
    assign trk_ok  = (5'(i_item.track) < 5'(VOICES));
    assign idx_ok  = (11'(i_item.note_index) < 11'(NOTE_DEPTH));
    assign last_voice = (r_vidx == VW'(VOICES - 1));
    assign phase_sum  = r_phase[r_vidx] + r_step[r_vidx];

    // Note store write straight from the command transaction.
    assign mem_we    = accept && (i_item.command == psm_pkg::CMD_WRITE) && trk_ok && idx_ok;
    assign mem_waddr = note_addr(in_trk, IW'(i_item.note_index));

    psm_note_store #(
        .DEPTH (MDEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({i_item.note_length, i_item.note_period, i_item.note_delay}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    psm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Next state, store read address, divider launch.
    always_comb begin
        n_state   = r_state;
        mem_raddr = note_addr(r_vidx, r_next[r_vidx][IW-1:0]);
        div_start = 1'b0;
        div_num   = psm_pkg::DIV_STEP_NUM;
        div_den   = r_per;
        unique case (r_state)
            psm_pkg::S_IDLE: begin
                mem_raddr = note_addr(in_trk, IW'(0));
                if (accept) begin
                    if (i_item.command == psm_pkg::CMD_TICK) begin
                        n_state = psm_pkg::S_VOICE;
                    end else if (i_item.command == psm_pkg::CMD_BIND && trk_ok) begin
                        n_state = psm_pkg::S_BIND;
                    end
                end
            end
            psm_pkg::S_BIND: begin
                n_state = psm_pkg::S_IDLE;
            end
            psm_pkg::S_VOICE: begin
                n_state = psm_pkg::S_MIX;
                if (r_armed[r_vidx] && !r_on[r_vidx]
                    && (r_next[r_vidx] < r_cnt[r_vidx]) && (r_delay[r_vidx] == 24'd0)) begin
                    n_state = psm_pkg::S_NOTE_RD;
                end
            end
            psm_pkg::S_NOTE_RD: begin
                n_state = psm_pkg::S_NEXT_RD;
            end
            psm_pkg::S_NEXT_RD: begin
                if (r_shdiv[r_vidx] > 8'd1) begin
                    div_start = 1'b1;
                    div_num   = psm_pkg::DIV_NW'(r_per);
                    div_den   = psm_pkg::DIV_DW'(r_shdiv[r_vidx]);
                    n_state   = psm_pkg::S_DIV1;
                end else begin
                    n_state = psm_pkg::S_PREP2;
                end
            end
            psm_pkg::S_DIV1: begin
                if (div_done) n_state = psm_pkg::S_PREP2;
            end
            psm_pkg::S_PREP2: begin
                if (r_per == 16'd0) begin
                    n_state = psm_pkg::S_APPLY;
                end else begin
                    div_start = 1'b1;
                    n_state   = psm_pkg::S_DIV2;
                end
            end
            psm_pkg::S_DIV2: begin
                if (div_done) n_state = psm_pkg::S_APPLY;
            end
            psm_pkg::S_APPLY: begin
                n_state = psm_pkg::S_MIX;
            end
            psm_pkg::S_MIX: begin
                n_state = last_voice ? psm_pkg::S_OUT : psm_pkg::S_VOICE;
            end
            psm_pkg::S_OUT: begin
                n_state = psm_pkg::S_IDLE;
            end
            default: begin
                n_state = psm_pkg::S_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psm_pkg::S_IDLE;
            r_vidx  <= '0;
            r_level <= psm_pkg::LEVEL_RST;
            r_clip  <= psm_pkg::CLIP_RST;
            for (int k = 0; k < VOICES; k++) begin
                r_phase[k] <= '0;
                r_step[k]  <= '0;
                r_on[k]    <= 1'b0;
                r_armed[k] <= 1'b0;
                r_next[k]  <= '0;
                r_cnt[k]   <= '0;
                r_delay[k] <= '0;
                r_dur[k]   <= '0;
                r_shdiv[k] <= 8'd1;
            end
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (paddr[2] == psm_pkg::REG_LEVEL) r_level <= pwdata[6:0];
                else r_clip <= pwdata[7:0];
            end
            unique case (r_state)
                psm_pkg::S_IDLE: begin
                    if (accept) begin
                        if (i_item.command == psm_pkg::CMD_OFF) begin
                            for (int k = 0; k < VOICES; k++) begin
                                r_on[k]  <= 1'b0;
                                r_dur[k] <= '0;
                            end
                        end
                        if (i_item.command == psm_pkg::CMD_TICK) begin
                            r_vidx <= '0;
                        end else begin
                            r_vidx <= in_trk;
                        end
                    end
                end
                psm_pkg::S_BIND: begin
                    r_cnt[r_vidx]   <= r_bind_n;
                    r_next[r_vidx]  <= '0;
                    r_delay[r_vidx] <= (r_bind_n != '0) ? mem_rdata[23:0] : 24'd0;
                    r_dur[r_vidx]   <= '0;
                    r_shdiv[r_vidx] <= (r_bind_sh == 8'd0) ? 8'd1 : r_bind_sh;
                    r_armed[r_vidx] <= (r_bind_n != '0);
                end
                psm_pkg::S_VOICE: begin
                    if (r_armed[r_vidx]) begin
                        if (r_on[r_vidx]) begin
                            if (r_dur[r_vidx] != 24'd0) r_dur[r_vidx] <= count_down(r_dur[r_vidx]);
                            else r_on[r_vidx] <= 1'b0;
                        end else if (r_next[r_vidx] >= r_cnt[r_vidx]) begin
                            r_armed[r_vidx] <= 1'b0;
                        end else if (r_delay[r_vidx] != 24'd0) begin
                            r_delay[r_vidx] <= count_down(r_delay[r_vidx]);
                        end else begin
                            r_next[r_vidx] <= r_next[r_vidx] + NW'(1);
                        end
                    end
                end
                psm_pkg::S_NEXT_RD: begin
                    // store now returns the following note; its delay arms the gap
                    if (r_next[r_vidx] < r_cnt[r_vidx]) r_delay[r_vidx] <= mem_rdata[23:0];
                end
                psm_pkg::S_APPLY: begin
                    r_phase[r_vidx] <= '0;
                    r_step[r_vidx]  <= r_nstep;
                    r_on[r_vidx]    <= (r_nstep != 32'd0);
                    r_dur[r_vidx]   <= r_ndur;
                end
                psm_pkg::S_MIX: begin
                    if (r_on[r_vidx]) r_phase[r_vidx] <= phase_sum;
                    if (!last_voice) r_vidx <= r_vidx + VW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers (no reset needed).
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bind_n  <= (11'(i_item.note_count) > 11'(NOTE_DEPTH))
                         ? NW'(NOTE_DEPTH) : NW'(i_item.note_count);
            r_bind_sh <= i_item.shift_div;
            r_acc     <= '0;
            r_mask    <= '0;
        end
        if (r_state == psm_pkg::S_NOTE_RD) begin
            r_per  <= mem_rdata[39:24];
            r_ndur <= mem_rdata[63:40];
        end
        if (r_state == psm_pkg::S_DIV1 && div_done) begin
            r_per <= div_quot[15:0];
        end
        if (r_state == psm_pkg::S_PREP2) begin
            r_nstep <= '0;
        end
        if (r_state == psm_pkg::S_DIV2 && div_done) begin
            r_nstep <= div_quot;
        end
        if (r_state == psm_pkg::S_MIX && r_on[r_vidx]) begin
            // square wave: phase sign bit picks +level or -level
            if (phase_sum[31]) r_acc <= r_acc + ACC_W'(r_level);
            else r_acc <= r_acc - ACC_W'(r_level);
            if (5'(r_vidx) < 5'd4) r_mask[2'(r_vidx)] <= 1'b1;
        end
    end

    // Output: clamp to +/-clip_limit, bias by 128, clamp to a byte.
    logic signed [ACC_W-1:0] lim;
    logic signed [ACC_W-1:0] clamped;
    logic signed [10:0]      biased;

    always_comb begin
        lim = ACC_W'({1'b0, r_clip});
        if (r_acc > lim) clamped = lim;
        else if (r_acc < -lim) clamped = -lim;
        else clamped = r_acc;
        biased = $signed({clamped[9], clamped[9:0]}) + 11'sd128;
        o_result.active_voices = r_mask;
        if (biased < 11'sd0) o_result.pwm_level = 8'd0;
        else if (biased > 11'sd255) o_result.pwm_level = 8'd255;
        else o_result.pwm_level = biased[7:0];
    end

    assign o_res_valid = (r_state == psm_pkg::S_OUT);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == psm_pkg::REG_CLIP_LIMIT) ? 32'(r_clip) : 32'(r_level);

    `PSM_ASSERT(a_no_res_on_cmd, cmd_acc |=> !o_res_valid, "result after non-tick command")
    `PSM_ASSERT(a_res_one_cycle, o_res_valid |=> !o_res_valid, "result held over one cycle")
    `PSM_ASSERT_RST(a_reset_idle, !i_rst_n |=> (!o_res_valid && !busy), "not idle after reset")
endmodule
